// ----- design/spi_pkg.sv -----
`default_nettype none
package spi_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DET_W   = PROD_W + 1;
  localparam int WIDE_W  = 53;
  localparam int NUM_W   = 52;
  localparam int DEN_W   = 34;
  localparam int SHIFT_W = 6;

  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_ONE  = 2'd1;
  localparam logic [1:0] VERDICT_MANY = 2'd2;

  // job kinds handed from front to back
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_MANY  = 2'd2;
  localparam logic [1:0] KIND_DIV   = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_start_x;
    logic signed [COORD_W-1:0] first_start_y;
    logic signed [COORD_W-1:0] first_end_x;
    logic signed [COORD_W-1:0] first_end_y;
    logic signed [COORD_W-1:0] second_start_x;
    logic signed [COORD_W-1:0] second_start_y;
    logic signed [COORD_W-1:0] second_end_x;
    logic signed [COORD_W-1:0] second_end_y;
  } spi_req_t;

  typedef struct packed {
    logic [1:0]              verdict;
    logic signed [NUM_W-1:0] point_x_numerator;
    logic signed [NUM_W-1:0] point_y_numerator;
    logic [DEN_W-1:0]        shared_denominator;
  } spi_res_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [WIDE_W-1:0] num_x;
    logic signed [WIDE_W-1:0] num_y;
    logic signed [DET_W-1:0]  den;
  } spi_job_t;

endpackage
`default_nettype wire

// ----- design/segment_pair_intersection_core.sv -----
// Segment pair intersection core.
//
// Request channel: drive req with two segments and raise start; the request
// is taken at a rising edge where start is high and busy is low. Only the
// low COORD_BITS bits of each coordinate are used, sign-extended.
// Result channel: done pulses for one cycle with result valid in that cycle.
// verdict 0 = no common point, 1 = one point, 2 = infinitely many. For a
// single point the coordinates are point_{x,y}_numerator over the positive
// shared_denominator, reduced; otherwise all three are zero.
// The front (products, determinant, classification) steps through MUL1,
// SUM and MUL2 and pushes the job into a two-entry queue from PUSH,
// waiting there while the queue is full. The back finishes non-crossing
// cases in the cycle after the pop. Crossing cases run two binary GCD
// loops (one subtract or shift per cycle on the 53-bit magnitudes) and then
// a 53-step restoring division of all three values in parallel.
// busy is high while the front works in MUL1, SUM, MUL2 and PUSH, held in
// PUSH while the queue is full; results come out in request order.
// Reset clears the front, queue and back; no result is pending after it.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none
module segment_pair_intersection_core import spi_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire spi_req_t req,
  output logic          busy,
  output logic          done,
  output spi_res_t      result
);

  logic     push, full, pop, empty;
  spi_job_t push_job, pop_job;

  // front: capture, multiply and classify
  spi_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .push (push),
    .job  (push_job),
    .full (full)
  );

  // hold jobs between the two sides
  spi_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (full),
    .pop     (pop),
    .pop_job (pop_job),
    .empty   (empty)
  );

  // back: reduce by GCD and drive the result
  spi_back u_back (
    .clk   (clk),
    .rst   (rst),
    .job   (pop_job),
    .empty (empty),
    .pop   (pop),
    .done  (done),
    .result(result)
  );

endmodule
`default_nettype wire

// ----- design/spi_front.sv -----
`default_nettype none
module spi_front import spi_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire spi_req_t req,
  output logic          busy,
  output logic          push,
  output spi_job_t      job,
  input  wire logic     full
);

  localparam int SH = COORD_W - COORD_BITS;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL1 = 3'd1;
  localparam logic [2:0] F_SUM  = 3'd2;
  localparam logic [2:0] F_MUL2 = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  localparam logic [1:0] LOC_OUT   = 2'd0;
  localparam logic [1:0] LOC_START = 2'd1;
  localparam logic [1:0] LOC_END   = 2'd2;
  localparam logic [1:0] LOC_IN    = 2'd3;

  logic [2:0] state;
  logic signed [COORD_W-1:0] raw [8];
  logic signed [COORD_W-1:0] ext [8];
  logic signed [COORD_W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [DIFF_W-1:0] ux, uy, wx, wy, ox, oy;
  logic signed [PROD_W-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [DET_W-1:0] det, tt, uu;
  logic signed [WIDE_W-1:0] m0, m1, m2, m3;
  logic pt1, pt2;
  logic [1:0] kind, kind_next;
  logic signed [COORD_W-1:0] px, py, px_next, py_next;
  logic [1:0] la, lb, lc, ld, lp1, lp3;

  function automatic logic in_span(input logic signed [DET_W-1:0] d,
                                   input logic signed [DET_W-1:0] s);
    if (s > 0) begin
      return (d >= 0) && (d <= s);
    end
    return (d <= 0) && (d >= s);
  endfunction

  function automatic logic [1:0] locate(
    input logic signed [COORD_W-1:0] ax, input logic signed [COORD_W-1:0] ay,
    input logic signed [COORD_W-1:0] bx, input logic signed [COORD_W-1:0] by,
    input logic signed [COORD_W-1:0] qx, input logic signed [COORD_W-1:0] qy);
    logic signed [DET_W-1:0] dx, dy, sx, sy;
    dx = DET_W'(qx) - DET_W'(ax);
    dy = DET_W'(qy) - DET_W'(ay);
    sx = DET_W'(bx) - DET_W'(ax);
    sy = DET_W'(by) - DET_W'(ay);
    if (ax == qx && ay == qy) begin
      return LOC_START;
    end
    if (bx == qx && by == qy) begin
      return LOC_END;
    end
    if (in_span(dx, sx) && in_span(dy, sy)) begin
      return LOC_IN;
    end
    return LOC_OUT;
  endfunction

  always_comb begin
    raw[0] = req.first_start_x;
    raw[1] = req.first_start_y;
    raw[2] = req.first_end_x;
    raw[3] = req.first_end_y;
    raw[4] = req.second_start_x;
    raw[5] = req.second_start_y;
    raw[6] = req.second_end_x;
    raw[7] = req.second_end_y;
    for (int i = 0; i < 8; i++) begin
      ext[i] = (raw[i] <<< SH) >>> SH;
    end
  end

  assign ux = DIFF_W'(x2) - DIFF_W'(x1);
  assign uy = DIFF_W'(y2) - DIFF_W'(y1);
  assign wx = DIFF_W'(x4) - DIFF_W'(x3);
  assign wy = DIFF_W'(y4) - DIFF_W'(y3);
  assign ox = DIFF_W'(x1) - DIFF_W'(x3);
  assign oy = DIFF_W'(y1) - DIFF_W'(y3);

  assign la  = locate(x1, y1, x2, y2, x3, y3);
  assign lb  = locate(x1, y1, x2, y2, x4, y4);
  assign lc  = locate(x3, y3, x4, y4, x1, y1);
  assign ld  = locate(x3, y3, x4, y4, x2, y2);
  assign lp1 = lc;
  assign lp3 = la;

  // classify from registered det, t and u
  always_comb begin
    kind_next = KIND_NONE;
    px_next   = x1;
    py_next   = y1;
    priority if (pt1 && pt2) begin
      if (x1 == x3 && y1 == y3) kind_next = KIND_POINT;
    end else if (pt1) begin
      if (tt == 0 && lp1 != LOC_OUT) kind_next = KIND_POINT;
    end else if (pt2) begin
      px_next = x3;
      py_next = y3;
      if (uu == 0 && lp3 != LOC_OUT) kind_next = KIND_POINT;
    end else if (det != 0) begin
      if (in_span(tt, det) && in_span(uu, det)) kind_next = KIND_DIV;
    end else if (uu != 0) begin
      kind_next = KIND_NONE;
    end else begin
      priority if (la == LOC_IN || lb == LOC_IN || lc == LOC_IN || ld == LOC_IN) begin
        kind_next = KIND_MANY;
      end else if ((la == LOC_START && lb == LOC_END) ||
                   (la == LOC_END && lb == LOC_START)) begin
        kind_next = KIND_MANY;
      end else if (la != LOC_OUT) begin
        kind_next = KIND_POINT;
        px_next   = x3;
        py_next   = y3;
      end else if (lb != LOC_OUT) begin
        kind_next = KIND_POINT;
        px_next   = x4;
        py_next   = y4;
      end else begin
        kind_next = KIND_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (start) state <= F_MUL1;
        F_MUL1: state <= F_SUM;
        F_SUM:  state <= F_MUL2;
        F_MUL2: state <= F_PUSH;
        F_PUSH: if (!full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      x1 <= ext[0]; y1 <= ext[1]; x2 <= ext[2]; y2 <= ext[3];
      x3 <= ext[4]; y3 <= ext[5]; x4 <= ext[6]; y4 <= ext[7];
    end
    if (state == F_MUL1) begin
      p0  <= PROD_W'(ux) * PROD_W'(wy);
      p1  <= PROD_W'(wx) * PROD_W'(uy);
      p2  <= PROD_W'(wx) * PROD_W'(oy);
      p3  <= PROD_W'(ox) * PROD_W'(wy);
      p4  <= PROD_W'(ux) * PROD_W'(oy);
      p5  <= PROD_W'(ox) * PROD_W'(uy);
      pt1 <= (ux == 0) && (uy == 0);
      pt2 <= (wx == 0) && (wy == 0);
    end
    if (state == F_SUM) begin
      det <= DET_W'(p0) - DET_W'(p1);
      tt  <= DET_W'(p2) - DET_W'(p3);
      uu  <= DET_W'(p4) - DET_W'(p5);
    end
    if (state == F_MUL2) begin
      m0   <= WIDE_W'(x3) * WIDE_W'(det);
      m1   <= WIDE_W'(uu) * WIDE_W'(wx);
      m2   <= WIDE_W'(y3) * WIDE_W'(det);
      m3   <= WIDE_W'(uu) * WIDE_W'(wy);
      kind <= kind_next;
      px   <= px_next;
      py   <= py_next;
    end
  end

  always_comb begin
    job.kind  = kind;
    job.den   = det;
    if (kind == KIND_DIV) begin
      job.num_x = m0 + m1;
      job.num_y = m2 + m3;
    end else begin
      job.num_x = WIDE_W'(px);
      job.num_y = WIDE_W'(py);
    end
  end

  assign busy = (state != F_IDLE);
  assign push = (state == F_PUSH) && !full;

endmodule
`default_nettype wire

// ----- design/spi_queue.sv -----
`default_nettype none
module spi_queue import spi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire spi_job_t push_job,
  output logic          full,
  input  wire logic     pop,
  output spi_job_t      pop_job,
  output logic          empty
);

  spi_job_t   slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  assign pop_job = slots[rd_ptr];
  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);

endmodule
`default_nettype wire

// ----- design/spi_back.sv -----
`default_nettype none
module spi_back import spi_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire spi_job_t job,
  input  wire logic     empty,
  output logic          pop,
  output logic          done,
  output spi_res_t      result
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_G1   = 3'd1;
  localparam logic [2:0] B_G2   = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_FIN  = 3'd4;
  localparam logic [SHIFT_W-1:0] LAST_STEP = SHIFT_W'(WIDE_W - 1);

  logic [2:0] state;
  logic [WIDE_W-1:0] ga, gb, gval, gdiv, mx, my, md;
  logic [SHIFT_W-1:0] k, cnt;
  logic gdone, neg_x, neg_y;
  logic [WIDE_W-1:0] quo [3];
  logic [WIDE_W:0] rem [3];
  logic [WIDE_W-1:0] quo_next [3];
  logic [WIDE_W:0] rem_next [3];
  logic [WIDE_W:0] rem_sh [3];
  logic signed [WIDE_W-1:0] den_ext;
  logic sd;

  assign gdone   = (ga == '0) || (gb == '0);
  assign gval    = ((ga == '0) ? gb : ga) << k;
  assign den_ext = WIDE_W'(job.den);
  assign sd      = job.den[DET_W-1];

  // one restoring step per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem[i][WIDE_W-1:0], quo[i][WIDE_W-1]};
      if (rem_sh[i] >= {1'b0, gdiv}) begin
        rem_next[i] = rem_sh[i] - {1'b0, gdiv};
        quo_next[i] = {quo[i][WIDE_W-2:0], 1'b1};
      end else begin
        rem_next[i] = rem_sh[i];
        quo_next[i] = {quo[i][WIDE_W-2:0], 1'b0};
      end
    end
  end

  assign pop = (state == B_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            if (job.kind == KIND_DIV) begin
              state <= B_G1;
            end else begin
              done <= 1'b1;
            end
          end
        end
        B_G1: if (gdone) state <= B_G2;
        B_G2: if (gdone) state <= B_DIV;
        B_DIV: if (cnt == LAST_STEP) state <= B_FIN;
        B_FIN: begin
          done  <= 1'b1;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        mx    <= job.num_x[WIDE_W-1] ? WIDE_W'(-job.num_x) : WIDE_W'(job.num_x);
        my    <= job.num_y[WIDE_W-1] ? WIDE_W'(-job.num_y) : WIDE_W'(job.num_y);
        md    <= sd ? WIDE_W'(-den_ext) : WIDE_W'(den_ext);
        ga    <= sd ? WIDE_W'(-den_ext) : WIDE_W'(den_ext);
        gb    <= job.num_x[WIDE_W-1] ? WIDE_W'(-job.num_x) : WIDE_W'(job.num_x);
        k     <= '0;
        neg_x <= job.num_x[WIDE_W-1] ^ sd;
        neg_y <= job.num_y[WIDE_W-1] ^ sd;
        unique case (job.kind)
          KIND_POINT: begin
            result.verdict            <= VERDICT_ONE;
            result.point_x_numerator  <= NUM_W'(job.num_x);
            result.point_y_numerator  <= NUM_W'(job.num_y);
            result.shared_denominator <= DEN_W'(1);
          end
          KIND_MANY: begin
            result.verdict            <= VERDICT_MANY;
            result.point_x_numerator  <= '0;
            result.point_y_numerator  <= '0;
            result.shared_denominator <= '0;
          end
          default: begin
            result.verdict            <= VERDICT_NONE;
            result.point_x_numerator  <= '0;
            result.point_y_numerator  <= '0;
            result.shared_denominator <= '0;
          end
        endcase
      end
      B_G1, B_G2: begin
        if (gdone) begin
          if (state == B_G1) begin
            ga <= gval;
            gb <= my;
            k  <= '0;
          end else begin
            gdiv   <= gval;
            quo[0] <= mx;
            quo[1] <= my;
            quo[2] <= md;
            rem[0] <= '0;
            rem[1] <= '0;
            rem[2] <= '0;
            cnt    <= '0;
          end
        end else if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          k  <= k + SHIFT_W'(1);
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (ga >= gb) begin
          ga <= (ga - gb) >> 1;
        end else begin
          gb <= (gb - ga) >> 1;
        end
      end
      B_DIV: begin
        for (int i = 0; i < 3; i++) begin
          quo[i] <= quo_next[i];
          rem[i] <= rem_next[i];
        end
        cnt <= cnt + SHIFT_W'(1);
      end
      B_FIN: begin
        result.verdict            <= VERDICT_ONE;
        result.point_x_numerator  <= neg_x ? -NUM_W'(quo[0]) : NUM_W'(quo[0]);
        result.point_y_numerator  <= neg_y ? -NUM_W'(quo[1]) : NUM_W'(quo[1]);
        result.shared_denominator <= DEN_W'(quo[2]);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/spi_checker.sv -----
`default_nettype none
module spi_checker import spi_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done,
  input wire spi_res_t result
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("activity right after reset");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("front not busy after taking a request");

  a_verdict: assert property (@(posedge clk) disable iff (rst)
    done |-> result.verdict == VERDICT_NONE || result.verdict == VERDICT_ONE ||
             result.verdict == VERDICT_MANY)
    else $error("bad verdict");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    done && result.verdict != VERDICT_ONE |->
      result.point_x_numerator == '0 && result.point_y_numerator == '0 &&
      result.shared_denominator == '0)
    else $error("point fields not cleared");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && result.verdict == VERDICT_ONE |-> result.shared_denominator != '0)
    else $error("zero denominator on a point");

endmodule

bind segment_pair_intersection_core spi_checker u_spi_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
`default_nettype wire
